/* rtl/core/box_filter_3x3_mean_top_defines.svh */
// assertion macros shared by the filter rtl
`ifndef BOX_FILTER_3X3_MEAN_TOP_DEFINES_SVH
`define BOX_FILTER_3X3_MEAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BFM_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("bfm assertion failed");
// next-cycle implication
`define BFM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("bfm assertion failed");
`else
`define BFM_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define BFM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

/* rtl/core/bfm_pkg.sv */
package bfm_pkg;

  localparam int PIX_W         = 8;
  localparam int COL_W         = 10;
  localparam int ROW_W         = 12;
  localparam int CFG_WIDTH_W   = 11;
  localparam int CFG_HEIGHT_W  = 12;
  localparam int WUSE_W        = 13;   // clamped width, up to 8191
  localparam int WIN_N         = 9;
  localparam int SUM_W         = 12;   // 9 * 255 = 2295
  localparam int RECIP_W       = 13;
  localparam int RECIP_SHIFT   = 16;
  localparam int MIN_SIZE      = 3;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 32;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = CFG_HEIGHT_W'(480);

  // floor(x * 7282 / 2^16) == floor(x / 9) for x <= 2295
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

/* rtl/core/bfm_ram.sv */
module bfm_ram
  import bfm_pkg::*;
#(
  parameter int WIDTH = PIX_W,
  parameter int DEPTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

/* rtl/core/box_filter_3x3_mean_top.sv */
// 3x3 box (mean) filter over one 8-bit pixel stream in raster order.
// in_*  : one pixel per request in in_tdata[7:0]; accepted when in_tvalid and
//         in_tready are both high. One pixel per clock is sustained while the output is taken.
// out_* : one request per interior pixel (not on the one-pixel frame border):
//         floor(3x3 sum / 9) with the center column and row. Border pixels
//         produce nothing.
// cfg_* : apb-style register port, image_width at 0x0, image_height at 0x4,
//         written in the access phase; pready is tied high.
// pipeline: accept/line-buffer read -> window shift -> 9-way sum -> multiply
//         by the reciprocal of 9 into the output register; a result passes
//         these stages in order. Throughput is one pixel per cycle while no
//         stage stalls: each line buffer takes one read and one write per
//         cycle on separate ports.
// stalls: each stage advances when the stage after it is empty or moving, so
//         bubbles are squeezed out and pixels keep flowing while a result
//         waits in the output register; in_tready drops only when every stage
//         holds a request.
// reset: counters go to row 0 column 0, the window clears, width/height go
//         to 640/480. Line buffers are not cleared; they are only read into a
//         result after two rows have refilled them, so no clearing pass runs.
`include "box_filter_3x3_mean_top_defines.svh"

module box_filter_3x3_mean_top
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel in
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,     // [7:0] pixel
  // mean out
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // [7:0] mean_value, [17:8] center_col,
                                              // [29:18] center_row, [31:30] zero
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam logic [WUSE_W-1:0] MAX_W_L = WUSE_W'(MAX_WIDTH);
  localparam int PAD_W = OUT_DATA_W - PIX_W - COL_W - ROW_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  img_width_r;
  logic [CFG_HEIGHT_W-1:0] img_height_r;
  cfg_reg_t                cfg_sel;
  logic                    cfg_wr;

  assign cfg_sel    = cfg_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= WIDTH_RST;
      img_height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_IMAGE_WIDTH:  img_width_r  <= cfg_pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: img_height_r <= cfg_pwdata[CFG_HEIGHT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_IMAGE_WIDTH:  cfg_prdata = APB_DATA_W'(img_width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = APB_DATA_W'(img_height_r);
    endcase
  end

  // clamp the width to what the buffers can hold, and both sizes to the minimum
  logic [WUSE_W-1:0]       w_use;
  logic [CFG_HEIGHT_W-1:0] h_use;

  always_comb begin
    w_use = WUSE_W'(img_width_r);
    if (w_use < WUSE_W'(MIN_SIZE)) begin
      w_use = WUSE_W'(MIN_SIZE);
    end else if (w_use > MAX_W_L) begin
      w_use = MAX_W_L;
    end
    h_use = img_height_r;
    if (h_use < CFG_HEIGHT_W'(MIN_SIZE)) begin
      h_use = CFG_HEIGHT_W'(MIN_SIZE);
    end
  end

  // ---------------------------------------------------------------------------
  // stage enables: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en_out, en3, en2, en1, acc;

  assign en_out    = !out_valid_r || out_tready;
  assign en3       = !v3_r || en_out;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign acc       = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // raster counters (position of the pixel being accepted)
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]  col_r, col_nxt, c_cur;
  logic [ROW_W-1:0]  row_r, row_nxt, r_cur;
  logic [ROW_W:0]    r_pre;
  logic [ROW_W:0]    r_inc;
  logic [COL_W:0]    c_inc;
  logic              emit;

  always_comb begin
    // size may have shrunk since the last pixel: wrap first
    if (WUSE_W'(col_r) >= w_use) begin
      c_cur = '0;
      r_pre = (ROW_W+1)'(row_r) + (ROW_W+1)'(1);
    end else begin
      c_cur = col_r;
      r_pre = (ROW_W+1)'(row_r);
    end
    if (r_pre >= (ROW_W+1)'(h_use)) begin
      r_cur = '0;
    end else begin
      r_cur = r_pre[ROW_W-1:0];
    end

    emit  = (c_cur >= COL_W'(2)) && (r_cur >= ROW_W'(2));

    c_inc = (COL_W+1)'(c_cur) + (COL_W+1)'(1);
    r_inc = (ROW_W+1)'(r_cur) + (ROW_W+1)'(1);
    if (WUSE_W'(c_inc) >= w_use) begin
      col_nxt = '0;
      if (r_inc >= (ROW_W+1)'(h_use)) begin
        row_nxt = '0;
      end else begin
        row_nxt = r_inc[ROW_W-1:0];
      end
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: pixel registered, line buffers read at its column
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] px_s1_r;
  logic [COL_W-1:0] col_s1_r;
  logic [ROW_W-1:0] row_s1_r;
  logic             emit_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px_s1_r   <= in_tdata[PIX_W-1:0];
      col_s1_r  <= c_cur;
      row_s1_r  <= r_cur;
      emit_s1_r <= emit;
    end
  end

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  above_rd, two_above_rd;

  assign ram_raddr = ADDR_W'(c_cur);
  assign ram_waddr = ADDR_W'(col_s1_r);
  assign ram_we    = v1_r && en2;

  // row above moves down into the row two above, the new pixel becomes row above
  bfm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (px_s1_r),
    .re    (acc),
    .raddr (ram_raddr),
    .rdata (above_rd)
  );

  bfm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_above (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (above_rd),
    .re    (acc),
    .raddr (ram_raddr),
    .rdata (two_above_rd)
  );

  // ---------------------------------------------------------------------------
  // stage 2: sliding window, index row*3+col, col 2 newest
  // ---------------------------------------------------------------------------
  logic [WIN_N-1:0][PIX_W-1:0] win_r, win_nxt;
  logic [COL_W-1:0]            col_s2_r;
  logic [ROW_W-1:0]            row_s2_r;

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = two_above_rd;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = above_rd;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = px_s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      v2_r  <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r && emit_s1_r;
      if (v1_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      col_s2_r <= col_s1_r - COL_W'(1);
      row_s2_r <= row_s1_r - ROW_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: window sum
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] win_sum, sum_s3_r;
  logic [COL_W-1:0] col_s3_r;
  logic [ROW_W-1:0] row_s3_r;

  always_comb begin
    win_sum = '0;
    for (int k = 0; k < WIN_N; k++) begin
      win_sum = win_sum + SUM_W'(win_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      sum_s3_r <= win_sum;
      col_s3_r <= col_s2_r;
      row_s3_r <= row_s2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // output register: divide by 9 through the reciprocal
  // ---------------------------------------------------------------------------
  logic [SUM_W+RECIP_W-1:0] quot_prod;
  logic [PIX_W-1:0]         out_mean_r;
  logic [COL_W-1:0]         out_col_r;
  logic [ROW_W-1:0]         out_row_r;

  assign quot_prod = (SUM_W+RECIP_W)'(sum_s3_r) * (SUM_W+RECIP_W)'(RECIP9);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v3_r) begin
      out_mean_r <= quot_prod[RECIP_SHIFT +: PIX_W];
      out_col_r  <= col_s3_r;
      out_row_r  <= row_s3_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_row_r, out_col_r, out_mean_r};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // consecutive pixels never touch the same line buffer entry in one cycle
  `BFM_ASSERT_IMPL(a_ram_no_rw_clash, clk, rst_n, ram_we && acc, ram_waddr != ram_raddr)
  // after an accept the column counter stays inside the clamped width
  `BFM_ASSERT_NEXT(a_col_in_width, clk, rst_n, acc, WUSE_W'(col_r) < $past(w_use))
  // only interior centers ever reach the output
  `BFM_ASSERT_IMPL(a_out_interior, clk, rst_n, out_valid_r,
                   (out_col_r != '0) && (out_row_r != '0))

endmodule

/* tb/tb_box_filter_3x3_mean_top.sv */
`timescale 1ns / 1ps

module tb_box_filter_3x3_mean_top;
  import bfm_pkg::*;

  // one result request as it sits in out_tdata, lowest field last
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] mean;
  } mean_result_t;

  // mirror of the filter: line buffers, window, counters and size registers,
  // plus the queue of means still owed by the block
  class box_mean_tracker;
    logic [PIX_W-1:0]        above     [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]        two_above [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]        win       [WIN_N];
    int                      col_next;
    int                      row_next;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    mean_result_t            owed_means[$];
    int                      mismatches;
    int                      pixels_seen;
    int                      means_checked;

    function new();
      foreach (above[i]) begin
        above[i]     = '0;
        two_above[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_next      = 0;
      row_next      = 0;
      width_reg     = WIDTH_RST;
      height_reg    = HEIGHT_RST;
      mismatches    = 0;
      pixels_seen   = 0;
      means_checked = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // sizes as the block uses them, out-of-range values clamped
    function int eff_width();
      int w;
      w = width_reg;
      if (w < MIN_SIZE) w = MIN_SIZE;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w;
    endfunction

    function int eff_height();
      int h;
      h = height_reg;
      if (h < MIN_SIZE) h = MIN_SIZE;
      return h;
    endfunction

    function bit at_frame_start();
      return col_next == 0 && row_next == 0;
    endfunction

    function void set_reg(cfg_reg_t which, logic [APB_DATA_W-1:0] v);
      case (which)
        REG_IMAGE_WIDTH:  width_reg  = v[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = v[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DATA_W-1:0] reg_value(cfg_reg_t which);
      if (which == REG_IMAGE_WIDTH) return APB_DATA_W'(width_reg);
      return APB_DATA_W'(height_reg);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int           w;
      int           h;
      int           c;
      int           r;
      int           sum;
      mean_result_t m;
      w = eff_width();
      h = eff_height();
      // size shrunk under a running frame: wrap before placing the pixel
      if (col_next >= w) begin
        col_next = 0;
        row_next++;
      end
      if (row_next >= h) row_next = 0;
      c = col_next;
      r = row_next;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2]       = two_above[c];
      win[5]       = above[c];
      two_above[c] = above[c];
      above[c]     = px;
      win[8]       = px;
      if (c >= 2 && r >= 2) begin
        sum = 0;
        foreach (win[k]) sum += win[k];
        m.mean = PIX_W'(sum / WIN_N);
        m.col  = COL_W'(c - 1);
        m.row  = ROW_W'(r - 1);
        owed_means.push_back(m);
      end
      col_next = c + 1;
      if (col_next >= w) begin
        col_next = 0;
        row_next = r + 1;
        if (row_next >= h) row_next = 0;
      end
      pixels_seen++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      mean_result_t got;
      mean_result_t want;
      got = d[$bits(mean_result_t)-1:0];
      if (owed_means.size() == 0) begin
        flag($sformatf("mean %0d at col %0d row %0d with nothing pending",
                       got.mean, got.col, got.row));
        return;
      end
      want = owed_means.pop_front();
      means_checked++;
      if (got.mean !== want.mean || got.col !== want.col || got.row !== want.row)
        flag($sformatf("mean/col/row expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       want.mean, want.col, want.row, got.mean, got.col, got.row));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;      // [7:0] pixel
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;     // [7:0] mean_value, [17:8] center_col,
                                        // [29:18] center_row, [31:30] zero
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  box_mean_tracker sb = new();

  // when set, neither side idles: back-to-back requests for a whole phase
  bit no_gaps    = 1'b0;
  int ready_hold = 0;
  int reg_writes = 0;
  int size_cuts  = 0;

  always #4 clk = ~clk;

  box_filter_3x3_mean_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // idle length before a pixel request: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // pixels lean toward the extremes so full-white and full-black windows occur
  function automatic logic [PIX_W-1:0] pick_pixel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic int pick_width();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(3, 12);
    if (roll < 95) return $urandom_range(13, 40);
    return $urandom_range(0, 2);    // clamps up to the minimum
  endfunction

  function automatic int pick_height();
    if ($urandom_range(0, 99) < 85) return $urandom_range(3, 7);
    return $urandom_range(0, 2);
  endfunction

  // receiver: ready runs and stalls of random length, changed at falling edges
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (no_gaps || $urandom_range(0, 99) < 65) begin
      out_tready <= 1'b1;
      ready_hold = $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b0;
      ready_hold = ($urandom_range(0, 99) < 94) ? $urandom_range(0, 3)
                                                : $urandom_range(10, 50);
    end
  end

  // every accepted result request is compared against the oldest owed mean
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // one pixel request; valid stays high into the next call when no gap follows
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
  endtask

  task automatic send_pixels(input int n);
    repeat (n) push_pixel(pick_pixel());
  endtask

  // run the counters back to row 0 column 0 at the current size
  task automatic finish_frame();
    while (!sb.at_frame_start()) push_pixel(pick_pixel());
  endtask

  // stop sending, let owed means come out, then give the pipeline time
  // to settle pixels that produce no result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.owed_means.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // setup cycle then access cycle; the transfer completes on pready
  task automatic apb_access(input logic wr, input cfg_reg_t which,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= APB_ADDR_W'(4 * int'(which));
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic read_back(input cfg_reg_t which);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, which, '0, rd);
    if (rd !== sb.reg_value(which))
      sb.flag($sformatf("register %s reads %0d, expected %0d",
                        which.name(), rd, sb.reg_value(which)));
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [APB_DATA_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, which, v, rd);
    sb.set_reg(which, v);
    reg_writes++;
    read_back(which);
  endtask

  task automatic set_size(input int w, input int h);
    drain();
    write_reg(REG_IMAGE_WIDTH, APB_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, APB_DATA_W'(h));
  endtask

  // shrink one dimension under a partly sent frame; only shrinking, so
  // every line buffer column read into a mean was filled by this frame
  task automatic cut_size();
    drain();
    if ($urandom_range(0, 1))
      write_reg(REG_IMAGE_WIDTH, APB_DATA_W'($urandom_range(0, sb.eff_width())));
    else
      write_reg(REG_IMAGE_HEIGHT, APB_DATA_W'($urandom_range(0, sb.eff_height())));
    size_cuts++;
  endtask

  initial begin
    int start;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // size registers come out of reset at 640 x 480
    read_back(REG_IMAGE_WIDTH);
    read_back(REG_IMAGE_HEIGHT);

    // smallest frame, all white: a single mean of full scale at (1,1)
    set_size(3, 3);
    repeat (9) push_pixel('1);
    // size values below the minimum clamp to 3 x 3; all black gives zero
    set_size(0, 2);
    repeat (9) push_pixel('0);
    // checkerboard: window sum of four full-scale pixels
    set_size(1, 0);
    for (int i = 0; i < 9; i++) push_pixel(((i % 3 + i / 3) % 2) ? '1 : '0);

    // all-ones width clamps to the widest line, tallest height; a short run
    // inside row 0, then the minimum size wraps the column mid-row
    set_size(2047, 4095);
    send_pixels($urandom_range(20, 60));
    set_size(3, 3);
    size_cuts++;
    finish_frame();

    // three rows and a bit at a medium size, then both sizes drop to the
    // minimum mid-frame so the counters wrap on column and row at once
    set_size(40, 7);
    send_pixels(3 * 40 + 10);
    set_size(3, 3);
    size_cuts++;
    finish_frame();

    // narrow and tall: a few dozen rows, then the height is cut below the
    // current row so the frame restarts at row 0
    set_size(3, 4095);
    send_pixels(3 * $urandom_range(20, 40) + $urandom_range(0, 2));
    drain();
    write_reg(REG_IMAGE_HEIGHT, APB_DATA_W'($urandom_range(0, 4)));
    size_cuts++;
    finish_frame();

    // random phases: whole frames at random small sizes, some of them
    // interrupted by a size cut, with idling switched off now and then
    start = sb.pixels_seen;
    while (sb.pixels_seen - start < 550) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      set_size(pick_width(), pick_height());
      repeat ($urandom_range(1, 2)) send_pixels(sb.eff_width() * sb.eff_height());
      if ($urandom_range(0, 2) == 0) begin
        send_pixels($urandom_range(1, sb.eff_width() * sb.eff_height() - 1));
        cut_size();
        finish_frame();
      end
    end
    no_gaps = 1'b0;

    drain();
    $display("%0d pixels sent, %0d means compared, %0d mismatches",
             sb.pixels_seen, sb.means_checked, sb.mismatches);
    $display("%0d register writes with read-back, %0d mid-frame size cuts",
             reg_writes, size_cuts);
    if (sb.mismatches == 0) begin
      $display("tb_box_filter_3x3_mean_top: clean");
    end else begin
      $display("tb_box_filter_3x3_mean_top: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_box_filter_3x3_mean_top: errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bfm_pkg.sv
rtl/core/bfm_ram.sv
rtl/core/box_filter_3x3_mean_top.sv
tb/tb_box_filter_3x3_mean_top.sv
